// ===== rtl/pfd_pkg.sv =====
// shared types and codes for the per-process descriptor table
// no dependencies
`default_nettype none

package pfd_pkg;

  // request type codes
  localparam logic [1:0] REQ_OPEN  = 2'd0;
  localparam logic [1:0] REQ_CLOSE = 2'd1;
  localparam logic [1:0] REQ_GET   = 2'd2;
  localparam logic [1:0] REQ_DROP  = 2'd3;

  // status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_INVAL    = 3'd1;
  localparam logic [2:0] STS_MFILE    = 3'd2;
  localparam logic [2:0] STS_BADF     = 3'd3;
  localparam logic [2:0] STS_NOTFOUND = 3'd4;

  // descriptors examined per scan cycle
  localparam int unsigned CHUNK = 8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] pid;
    logic        inode_present;
    logic [31:0] inode_handle;
    logic [31:0] oflags;
    logic [7:0]  fd;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  fd_out;
    logic [31:0] inode_out;
    logic [31:0] flags_out;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_CHECK,
    ST_READ,
    ST_SCAN
  } state_t;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CLAIM,
    CELL_DROP,
    CELL_SET,
    CELL_CLR
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [15:0] pid;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pfd_cell.sv =====
// one process slot: owner tag, used flag and the row of descriptor used bits
// depends on pfd_pkg; passes the free-slot chain to its neighbor
`default_nettype none

module pfd_cell import pfd_pkg::*; #(
  parameter int unsigned DESCRIPTORS = 64,
  parameter int unsigned DESC_W      = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cell_cmd_t              cmd,
  input  wire logic                   en,
  input  wire logic [DESC_W-1:0]      idx,
  input  wire logic                   free_in,
  output logic                        free_out,
  output logic                        first_free,
  output logic                        match,
  output logic [DESCRIPTORS-1:0]      row
);

  logic                   used_r;
  logic [15:0]            owner_r;
  logic [DESCRIPTORS-1:0] row_r;

  // chain and match outputs
  assign match      = used_r && (owner_r == cmd.pid);
  assign free_out   = free_in || !used_r;
  assign first_free = !used_r && !free_in;
  assign row        = row_r;

  // slot state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      row_r  <= '0;
    end else if (en) begin
      unique case (cmd.op)
        CELL_CLAIM: begin
          used_r <= 1'b1;
          row_r  <= '0;
        end
        CELL_DROP: begin
          used_r <= 1'b0;
          row_r  <= '0;
        end
        CELL_SET: row_r[idx] <= 1'b1;
        CELL_CLR: row_r[idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  // owner tag, no reset
  always_ff @(posedge clk) begin
    if (en && cmd.op == CELL_CLAIM) begin
      owner_r <= cmd.pid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/per_process_fd_table_core.sv =====
// per-process descriptor table: chain of slot cells, entry memory, control
// depends on pfd_pkg and pfd_cell
//
//  channel | ports                        | direction
//  in      | in_valid in_ready in_req     | request in
//  out     | out_valid out_ready out_res  | result out
//
// one request at a time; drop and errors found at match finish in the match state, close
// or an unused entry goes on to the check state, get adds the read state (registered
// entry memory read); open goes on from match to the scan state, which examines
// 8 descriptors of the row per cycle.
// reset clears slot used flags and row bits at once; handle memory needs no clear.
// a stalled result waits in the output register; the next request is taken meanwhile.
`default_nettype none

module per_process_fd_table_core import pfd_pkg::*; #(
  parameter int unsigned PROCESS_SLOTS    = 16,
  parameter int unsigned DESCRIPTORS      = 64,
  parameter int unsigned FIRST_DESCRIPTOR = 3
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_req,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  localparam int unsigned SLOT_W  = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int unsigned DESC_W  = $clog2(DESCRIPTORS);
  localparam int unsigned ENTRIES = PROCESS_SLOTS * DESCRIPTORS;
  localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NCH     = (DESCRIPTORS + CHUNK - 1) / CHUNK;
  localparam int unsigned CH_W    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PADW    = NCH * CHUNK;

  state_t              state_r, state_nxt;
  req_t                req_r;
  logic [SLOT_W-1:0]   sel_r, sel_nxt;
  logic [CH_W-1:0]     chunk_r, chunk_nxt;
  logic                out_valid_r;
  res_t                out_r;

  logic                go;
  logic                res_load;
  res_t                res;
  cell_cmd_t           cmd;
  logic [SLOT_W-1:0]   cell_sel;
  logic [DESC_W-1:0]   cell_idx;

  logic [PROCESS_SLOTS:0]   free_chain;
  logic [PROCESS_SLOTS-1:0] match_v, first_v;
  logic [DESCRIPTORS-1:0]   rows [PROCESS_SLOTS];
  logic [SLOT_W-1:0]        match_idx, free_idx;
  logic                     hit, any_free;
  logic [DESCRIPTORS-1:0]   sel_row;
  logic [PADW-1:0]          avail;
  logic [CHUNK-1:0]         chunk_bits;
  logic [2:0]               chunk_j;
  logic                     chunk_any;
  logic [8:0]               scan_d;
  logic                     fd_ok;

  logic [63:0]         mem [ENTRIES];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [DESC_W-1:0]   mem_desc;
  logic [63:0]         mem_q;

  assign free_chain[0] = 1'b0;

  // chain of slot cells
  for (genvar i = 0; i < PROCESS_SLOTS; i++) begin : g_cell
    pfd_cell #(
      .DESCRIPTORS (DESCRIPTORS),
      .DESC_W      (DESC_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .en         (cell_sel == SLOT_W'(i)),
      .idx        (cell_idx),
      .free_in    (free_chain[i]),
      .free_out   (free_chain[i+1]),
      .first_free (first_v[i]),
      .match      (match_v[i]),
      .row        (rows[i])
    );
  end

  // one-hot to index
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < PROCESS_SLOTS; i++) begin
      if (match_v[i]) match_idx = match_idx | SLOT_W'(i);
      if (first_v[i]) free_idx  = free_idx  | SLOT_W'(i);
    end
  end
  assign hit      = |match_v;
  assign any_free = free_chain[PROCESS_SLOTS];
  assign sel_row  = rows[sel_r];

  // free descriptors of the selected row, padded to whole chunks
  always_comb begin
    logic [PADW-1:0] row_pad;
    row_pad = '1;
    row_pad[DESCRIPTORS-1:0] = sel_row;
    for (int k = 0; k < PADW; k++) begin
      avail[k] = !row_pad[k] && (k >= FIRST_DESCRIPTOR) && (k < DESCRIPTORS);
    end
  end
  assign chunk_bits = avail[chunk_r*CHUNK +: CHUNK];
  assign chunk_any  = |chunk_bits;

  // lowest free bit in the chunk
  always_comb begin
    chunk_j = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (chunk_bits[j]) chunk_j = 3'(j);
    end
  end
  assign scan_d = 9'(chunk_r) * 9'(CHUNK) + 9'(chunk_j);

  assign fd_ok = (9'(req_r.fd) >= 9'(FIRST_DESCRIPTOR)) && (9'(req_r.fd) < 9'(DESCRIPTORS));
  assign go    = !out_valid_r || out_ready;

  // next state and control
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    chunk_nxt = chunk_r;
    cmd.op    = CELL_NOP;
    cmd.pid   = req_r.pid;
    cell_sel  = sel_r;
    cell_idx  = req_r.fd[DESC_W-1:0];
    mem_we    = 1'b0;
    mem_desc  = req_r.fd[DESC_W-1:0];
    res_load  = 1'b0;
    res       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        chunk_nxt = '0;
        priority if (req_r.req_type == REQ_OPEN) begin
          if (!req_r.inode_present || req_r.pid == 16'd0) begin
            res.status = STS_INVAL;
            res_load   = go;
          end else if (hit) begin
            sel_nxt   = match_idx;
            state_nxt = ST_SCAN;
          end else if (any_free) begin
            sel_nxt   = free_idx;
            cell_sel  = free_idx;
            cmd.op    = CELL_CLAIM;
            state_nxt = ST_SCAN;
          end else begin
            res.status = STS_MFILE;
            res_load   = go;
          end
        end else if (req_r.req_type == REQ_DROP) begin
          if (hit) begin
            res.status = STS_OK;
            res_load   = go;
            cell_sel   = match_idx;
            if (go) cmd.op = CELL_DROP;
          end else begin
            res.status = STS_NOTFOUND;
            res_load   = go;
          end
        end else begin
          if (fd_ok && hit) begin
            sel_nxt   = match_idx;
            state_nxt = ST_CHECK;
          end else begin
            res.status = STS_BADF;
            res_load   = go;
          end
        end
        if (res_load) state_nxt = ST_IDLE;
      end
      ST_CHECK: begin
        if (!sel_row[req_r.fd[DESC_W-1:0]]) begin
          res.status = STS_BADF;
          res_load   = go;
          if (go) state_nxt = ST_IDLE;
        end else if (req_r.req_type == REQ_CLOSE) begin
          res.status = STS_OK;
          res_load   = go;
          if (go) begin
            cmd.op    = CELL_CLR;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        res.status    = STS_OK;
        res.inode_out = mem_q[63:32];
        res.flags_out = mem_q[31:0];
        res_load      = go;
        if (go) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        mem_desc = scan_d[DESC_W-1:0];
        cell_idx = scan_d[DESC_W-1:0];
        if (chunk_any) begin
          res.status = STS_OK;
          res.fd_out = scan_d[5:0];
          res_load   = go;
          if (go) begin
            cmd.op    = CELL_SET;
            mem_we    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (chunk_r == CH_W'(NCH - 1)) begin
          res.status = STS_MFILE;
          res_load   = go;
          if (go) state_nxt = ST_IDLE;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    chunk_r <= chunk_nxt;
    if (in_valid && in_ready) req_r <= in_req;
    if (res_load) out_r <= res;
  end

  // entry memory: handle and flags
  assign mem_addr = ADDR_W'(sel_r) * ADDR_W'(DESCRIPTORS) + ADDR_W'(mem_desc);
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= {req_r.inode_handle, req_r.oflags};
    mem_q <= mem[mem_addr];
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

// ===== bench/per_process_fd_table_core_test.sv =====
// testbench for per_process_fd_table_core: directed and random requests
// checked against an in-bench model of the descriptor table; depends on pfd_pkg
`timescale 1ns / 100ps

module per_process_fd_table_core_test;
  import pfd_pkg::*;

  localparam int SLOTS = 16;
  localparam int DESCS = 64;
  localparam int FIRST = 3;

  // descriptor table model and queue of expected results
  class fd_table_board;
    bit          used_q[SLOTS];
    bit [15:0]   owner_q[SLOTS];
    bit          ent_used[SLOTS*DESCS];
    bit [31:0]   ent_ino[SLOTS*DESCS];
    bit [31:0]   ent_flg[SLOTS*DESCS];
    res_t        pending[$];
    int          errors;

    function int find_slot(bit [15:0] pid);
      for (int s = 0; s < SLOTS; s++)
        if (used_q[s] && owner_q[s] == pid) return s;
      return -1;
    endfunction

    function void clear_row(int s);
      for (int d = 0; d < DESCS; d++) begin
        ent_used[s*DESCS+d] = 0;
        ent_ino[s*DESCS+d] = 0;
        ent_flg[s*DESCS+d] = 0;
      end
    endfunction

    // note an accepted request and queue its result
    function void note_request(req_t r);
      res_t x;
      int s;
      int e;
      x = '0;
      case (r.req_type)
        REQ_OPEN: begin
          if (!r.inode_present || r.pid == 0) x.status = STS_INVAL;
          else begin
            s = find_slot(r.pid);
            if (s < 0)
              for (int d = 0; d < SLOTS; d++)
                if (!used_q[d]) begin
                  s = d; used_q[d] = 1; owner_q[d] = r.pid; clear_row(d);
                  break;
                end
            x.status = STS_MFILE;
            if (s >= 0)
              for (int d = FIRST; d < DESCS; d++) begin
                e = s*DESCS + d;
                if (!ent_used[e]) begin
                  ent_used[e] = 1; ent_ino[e] = r.inode_handle; ent_flg[e] = r.oflags;
                  x.fd_out = d[5:0]; x.status = STS_OK;
                  break;
                end
              end
          end
        end
        REQ_CLOSE, REQ_GET: begin
          x.status = STS_BADF;
          if (r.fd >= FIRST && r.fd < DESCS) begin
            s = find_slot(r.pid);
            if (s >= 0) begin
              e = s*DESCS + r.fd;
              if (ent_used[e]) begin
                x.status = STS_OK;
                if (r.req_type == REQ_CLOSE) begin
                  ent_used[e] = 0; ent_ino[e] = 0; ent_flg[e] = 0;
                end else begin
                  x.inode_out = ent_ino[e]; x.flags_out = ent_flg[e];
                end
              end
            end
          end
        end
        default: begin
          s = find_slot(r.pid);
          if (s < 0) x.status = STS_NOTFOUND;
          else begin
            used_q[s] = 0; owner_q[s] = 0; clear_row(s);
          end
        end
      endcase
      pending.push_back(x);
    endfunction

    // compare a result with the oldest expectation
    function void check_result(res_t got);
      res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t status exp %0d got %0d", $time, exp_r.status, got.status); errors++;
      end
      if (got.fd_out !== exp_r.fd_out) begin
        $display("%0t fd_out exp %0d got %0d", $time, exp_r.fd_out, got.fd_out); errors++;
      end
      if (got.inode_out !== exp_r.inode_out) begin
        $display("%0t inode_out exp %h got %h", $time, exp_r.inode_out, got.inode_out);
        errors++;
      end
      if (got.flags_out !== exp_r.flags_out) begin
        $display("%0t flags_out exp %h got %h", $time, exp_r.flags_out, got.flags_out);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 0;
  res_t out_res;
  bit   calm = 0;

  fd_table_board board = new();

  per_process_fd_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res)
  );

  always #6 clk = ~clk;

  // result side: random stalls, check on handshake
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_res);
    out_ready <= rst_n && (calm || $urandom_range(99) >= 23);
  end

  // send one request, with a random gap ahead of it
  task automatic send_request(req_t r);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_req <= r;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    board.note_request(r);
  endtask

  function automatic req_t make_req(bit [1:0] t, bit [15:0] pid, bit [7:0] fd);
    req_t r;
    r.req_type = t; r.pid = pid; r.fd = fd; r.inode_present = 1;
    r.inode_handle = $urandom; r.oflags = $urandom;
    return r;
  endfunction

  // pid pool kept small so slots and descriptors collide often
  function automatic bit [15:0] pick_pid();
    int k;
    k = $urandom_range(99);
    if (k < 3) return 16'h0;
    if (k < 6) return 16'($urandom);
    return 16'(16'h0100 + $urandom_range(19));
  endfunction

  initial begin
    req_t r;
    int k;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: errors, extremes, full row, full slot table
    r = make_req(REQ_OPEN, 16'h0, 8'd0); send_request(r);
    r = make_req(REQ_OPEN, 16'hffff, 8'd0); r.inode_present = 0; send_request(r);
    r = make_req(REQ_OPEN, 16'hffff, 8'hff);
    r.inode_handle = '1; r.oflags = '1; send_request(r);
    r = make_req(REQ_GET, 16'hffff, 8'd3); send_request(r);
    r = make_req(REQ_GET, 16'hffff, 8'd2); send_request(r);
    r = make_req(REQ_GET, 16'hffff, 8'd64); send_request(r);
    r = make_req(REQ_CLOSE, 16'hffff, 8'hff); send_request(r);
    r = make_req(REQ_CLOSE, 16'h1234, 8'd3); send_request(r);
    r = make_req(REQ_CLOSE, 16'hffff, 8'd4); send_request(r);
    r = make_req(REQ_CLOSE, 16'hffff, 8'd3); send_request(r);
    r = make_req(REQ_GET, 16'hffff, 8'd3); send_request(r);
    r = make_req(REQ_DROP, 16'h1234, 8'd0); send_request(r);
    r = make_req(REQ_DROP, 16'hffff, 8'd0); send_request(r);
    calm = 1;
    for (int i = 0; i < 62; i++) begin
      r = make_req(REQ_OPEN, 16'h0001, 8'd0);
      if (i == 0) begin r.inode_handle = '0; r.oflags = '0; end
      send_request(r);
    end
    r = make_req(REQ_GET, 16'h0001, 8'd63); send_request(r);
    calm = 0;
    for (int i = 2; i <= 18; i++) begin
      r = make_req(REQ_OPEN, i[15:0], 8'd0); send_request(r);
    end
    for (int i = 1; i <= 18; i++) begin
      r = make_req(REQ_DROP, i[15:0], 8'd0); send_request(r);
    end

    // random part
    for (int i = 0; i < 290; i++) begin
      k = $urandom_range(99);
      r = make_req(k < 45 ? REQ_OPEN : k < 65 ? REQ_GET : k < 88 ? REQ_CLOSE : REQ_DROP,
                   pick_pid(),
                   $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(12)));
      if ($urandom_range(19) == 0) r.inode_present = 0;
      calm = (i >= 150 && i < 220);
      send_request(r);
    end
    in_valid <= 0;
    calm = 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) $display("[per_process_fd_table_core] OK");
    else $display("[per_process_fd_table_core] ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("[per_process_fd_table_core] ERROR");
    $finish;
  end
endmodule
